/* rtl/assert_macros.svh */
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

`endif

/* rtl/mi3_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared constants and tables for the 3x3 matrix inverse block.
// ----------------------------------------------------------------------------
package mi3_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int ELEMS          = 9;
	localparam int EIW            = $clog2(ELEMS);

	// register index of the determinant threshold
	localparam int REG_DET_THR = 0;

	typedef logic [3:0] idx_t;

	// cofactor i = m[a]*m[b] - m[c]*m[d], row-major element indices
	localparam idx_t COF_IDX [ELEMS][4] = '{
		'{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
		'{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
		'{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
	};

endpackage

/* rtl/mi3_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_front
// Pipelined cofactor and determinant datapath with the invertibility test.
// ----------------------------------------------------------------------------
module mi3_front import mi3_pkg::*; #(
	parameter int DW = DATA_WIDTH_DEF,
	parameter int FB = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [DW-1:0] m [ELEMS],
	input  logic [DW-2:0]        thr,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [DW-1:0] m_o [ELEMS],
	output logic [2*DW-1:0]      cofmag [ELEMS],
	output logic [ELEMS-1:0]     cofneg,
	output logic [3*DW:0]        detmag,
	output logic                 detneg,
	output logic                 inv
);

	localparam int CW   = 2*DW + 1;
	localparam int DETW = 3*DW + 2;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en;

	logic signed [2*DW-1:0] pa_s1 [ELEMS];
	logic signed [2*DW-1:0] pb_s1 [ELEMS];
	logic signed [DW-1:0]   m_s1 [ELEMS];
	logic signed [CW-1:0]   cof_s2 [ELEMS];
	logic signed [DW-1:0]   m_s2 [ELEMS];
	logic signed [CW-1:0]   plo_s3 [3];
	logic signed [CW-1:0]   phi_s3 [3];
	logic signed [CW-1:0]   cof_s3 [ELEMS];
	logic signed [DW-1:0]   m_s3 [ELEMS];
	logic signed [DETW-1:0] term_s4 [3];
	logic signed [CW-1:0]   cof_s4 [ELEMS];
	logic signed [DW-1:0]   m_s4 [ELEMS];
	logic signed [DETW-1:0] det_s5;
	logic signed [CW-1:0]   cof_s5 [ELEMS];
	logic signed [DW-1:0]   m_s5 [ELEMS];
	logic [DETW-2:0]        dmag_s6;
	logic                   dneg_s6;
	logic [2*DW-1:0]        cmag_s6 [ELEMS];
	logic [ELEMS-1:0]       cneg_s6;
	logic signed [DW-1:0]   m_s6 [ELEMS];
	logic [DETW-2:0]        dmag_s7;
	logic                   dneg_s7;
	logic [2*DW-1:0]        cmag_s7 [ELEMS];
	logic [ELEMS-1:0]       cneg_s7;
	logic signed [DW-1:0]   m_s7 [ELEMS];
	logic                   inv_s7;

	logic [DETW-1:0] rsum;
	logic [DETW-1:0] rnd;

	// whole pipe moves when the last stage is empty or drained
	assign en       = !v_s7 || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6;
		end
	end

	// rounding of the determinant magnitude to the input format
	always_comb begin
		rsum = {1'b0, dmag_s6} + (DETW'(1) << (2*FB - 1));
		rnd  = rsum >> (2*FB);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: the eighteen element products
			for (int i = 0; i < ELEMS; i++) begin
				pa_s1[i] <= m[COF_IDX[i][0]] * m[COF_IDX[i][1]];
				pb_s1[i] <= m[COF_IDX[i][2]] * m[COF_IDX[i][3]];
			end
			m_s1 <= m;
			// s2: cofactors
			for (int i = 0; i < ELEMS; i++)
				cof_s2[i] <= CW'(pa_s1[i]) - CW'(pb_s1[i]);
			m_s2 <= m_s1;
			// s3: first-row expansion split into low and high halves
			for (int j = 0; j < 3; j++) begin
				plo_s3[j] <= CW'(m_s2[j]) * $signed({1'b0, cof_s2[3*j][DW-1:0]});
				phi_s3[j] <= CW'(m_s2[j]) * $signed(cof_s2[3*j][CW-1:DW]);
			end
			cof_s3 <= cof_s2;
			m_s3   <= m_s2;
			// s4: recombine halves
			for (int j = 0; j < 3; j++)
				term_s4[j] <= (DETW'(phi_s3[j]) <<< DW) + DETW'(plo_s3[j]);
			cof_s4 <= cof_s3;
			m_s4   <= m_s3;
			// s5: determinant
			det_s5 <= term_s4[0] + term_s4[1] + term_s4[2];
			cof_s5 <= cof_s4;
			m_s5   <= m_s4;
			// s6: sign and magnitude
			dneg_s6 <= det_s5[DETW-1];
			dmag_s6 <= det_s5[DETW-1] ? (DETW-1)'(-det_s5) : det_s5[DETW-2:0];
			for (int i = 0; i < ELEMS; i++) begin
				cneg_s6[i] <= cof_s5[i][CW-1];
				cmag_s6[i] <= cof_s5[i][CW-1] ? (2*DW)'(-cof_s5[i]) : cof_s5[i][2*DW-1:0];
			end
			m_s6 <= m_s5;
			// s7: threshold test
			inv_s7  <= rnd > DETW'(thr);
			dmag_s7 <= dmag_s6;
			dneg_s7 <= dneg_s6;
			cmag_s7 <= cmag_s6;
			cneg_s7 <= cneg_s6;
			m_s7    <= m_s6;
		end
	end

	assign out_valid = v_s7;
	assign m_o       = m_s7;
	assign cofmag    = cmag_s7;
	assign cofneg    = cneg_s7;
	assign detmag    = dmag_s7;
	assign detneg    = dneg_s7;
	assign inv       = inv_s7;

endmodule

/* rtl/mi3_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_queue
// Two-entry flip-flop queue between the front and back sections.
// ----------------------------------------------------------------------------
module mi3_queue import mi3_pkg::*; #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_valid,
	output logic         wr_ready,
	input  logic [W-1:0] wr_data,
	output logic         rd_valid,
	input  logic         rd_pop,
	output logic [W-1:0] rd_data
);

	logic [W-1:0] mem_q [2];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;
	logic         push;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign push     = wr_valid && wr_ready;
	assign rd_data  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (rd_pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(rd_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end

endmodule

/* rtl/mi3_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_back
// Shared restoring divider producing the nine quotients, plus output register.
// ----------------------------------------------------------------------------
module mi3_back import mi3_pkg::*; #(
	parameter int DW = DATA_WIDTH_DEF,
	parameter int FB = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	output logic                 q_pop,
	input  logic signed [DW-1:0] h_m [ELEMS],
	input  logic [2*DW-1:0]      h_cofmag [ELEMS],
	input  logic [ELEMS-1:0]     h_cofneg,
	input  logic [3*DW:0]        h_detmag,
	input  logic                 h_detneg,
	input  logic                 h_inv,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [DW-1:0] r [ELEMS],
	output logic                 invertible
);

	localparam int RW = 4*DW + 1;
	localparam int SW = $clog2(DW + 1);
	localparam logic [DW-1:0] LIM_POS = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] LIM_NEG = {1'b1, {(DW-1){1'b0}}};

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_DONE} state_t;

	state_t               state_q;
	logic [EIW-1:0]       elem_q;
	logic [SW-1:0]        step_q;
	logic [RW-1:0]        rem_q;
	logic [RW-1:0]        dsh_q;
	logic [DW:0]          quo_q;
	logic signed [DW-1:0] res_q [ELEMS];
	logic signed [DW-1:0] r_q [ELEMS];
	logic                 inv_q;
	logic                 ov_q;

	logic            out_free;
	logic            ge;
	logic [DW:0]     qn;
	logic            neg;
	logic [DW-1:0]   lim;
	logic [DW-1:0]   qmag;
	logic [DW-1:0]   qval;
	logic [RW-1:0]   dinit;
	logic [EIW-1:0]  elem_nx;
	logic [RW-1:0]   num_nx;

	assign out_free = !ov_q || out_ready;
	assign dinit    = RW'(h_detmag) << DW;
	assign elem_nx  = elem_q + EIW'(1);
	assign num_nx   = RW'(h_cofmag[elem_nx]) << (2*FB);

	// one quotient bit per cycle, then saturate and sign the finished element
	always_comb begin
		ge   = rem_q >= dsh_q;
		qn   = {quo_q[DW-1:0], ge};
		neg  = h_cofneg[elem_q] ^ h_detneg;
		lim  = neg ? LIM_NEG : LIM_POS;
		qmag = (qn[DW] || qn[DW-1:0] > lim) ? lim : qn[DW-1:0];
		qval = neg ? -qmag : qmag;
	end

	assign q_pop = (state_q == ST_IDLE && q_valid && !h_inv && out_free) ||
		(state_q == ST_DONE && out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q    <= 1'b0;
			elem_q  <= '0;
			step_q  <= '0;
		end else begin
			// output register is loaded exactly when an entry leaves the queue
			ov_q <= q_pop || (ov_q && !out_ready);
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						if (h_inv) begin
							state_q <= ST_DIV;
							elem_q  <= '0;
							step_q  <= '0;
							rem_q   <= RW'(h_cofmag[0]) << (2*FB);
							dsh_q   <= dinit;
							quo_q   <= '0;
						end else if (out_free) begin
							r_q   <= h_m;
							inv_q <= 1'b0;
						end
					end
				end
				ST_DIV: begin
					if (step_q == SW'(DW)) begin
						res_q[elem_q] <= qval;
						if (elem_q == EIW'(ELEMS - 1)) begin
							state_q <= ST_DONE;
						end else begin
							elem_q <= elem_nx;
							step_q <= '0;
							rem_q  <= num_nx;
							dsh_q  <= dinit;
							quo_q  <= '0;
						end
					end else begin
						if (ge) rem_q <= rem_q - dsh_q;
						dsh_q  <= dsh_q >> 1;
						quo_q  <= qn;
						step_q <= step_q + SW'(1);
					end
				end
				ST_DONE: begin
					if (out_free) begin
						r_q     <= res_q;
						inv_q   <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid  = ov_q;
	assign r          = r_q;
	assign invertible = inv_q;

endmodule

/* rtl/matrix_inverse_3x3.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_inverse_3x3
// Adjugate-method inverse of one signed fixed-point 3x3 matrix per beat.
// ----------------------------------------------------------------------------
// A seven-stage front pipeline forms the cofactors and determinant exactly
// and tests the rounded determinant magnitude against det_threshold, taking
// one matrix per cycle while its output is not stalled. A two-entry queue
// feeds the back section, which passes a non-invertible matrix straight to
// the output register and runs an invertible one through a single shared
// restoring divider, one quotient bit per cycle, taking no new matrix until
// all nine quotients are out.
module matrix_inverse_3x3 import mi3_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	localparam int PW  = (DATA_WIDTH - 1 > 32) ? 64 : 32,
	localparam int SL  = (PW == 64) ? 3 : 2,
	localparam int PAW = SL + 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [PAW-1:0]               paddr,
	input  logic [PW-1:0]                pwdata,
	output logic [PW-1:0]                prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [DATA_WIDTH-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [DATA_WIDTH-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22,
	output logic                         invertible
);

	localparam int DW = DATA_WIDTH;
	localparam int MB = 0;
	localparam int CB = ELEMS*DW;
	localparam int NB = CB + ELEMS*2*DW;
	localparam int DB = NB + ELEMS;
	localparam int EW = DB + 3*DW + 3;

	logic [DW-2:0] thr_q;
	logic          sel_thr;

	logic signed [DW-1:0] m_in [ELEMS];
	logic signed [DW-1:0] f_m [ELEMS];
	logic [2*DW-1:0]      f_cmag [ELEMS];
	logic [ELEMS-1:0]     f_cneg;
	logic [3*DW:0]        f_dmag;
	logic                 f_dneg, f_inv, f_valid, f_ready;
	logic [EW-1:0]        wr_ent, rd_ent;
	logic                 q_valid, q_pop;
	logic signed [DW-1:0] h_m [ELEMS];
	logic [2*DW-1:0]      h_cmag [ELEMS];
	logic signed [DW-1:0] r_o [ELEMS];

	// configuration register
	assign pready  = 1'b1;
	assign sel_thr = paddr[PAW-1:SL] == 1'(REG_DET_THR);
	assign prdata  = sel_thr ? PW'(thr_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= (DW-1)'(1);
		end else if (psel && penable && pwrite && pready && sel_thr) begin
			thr_q <= pwdata[DW-2:0];
		end
	end

	assign m_in = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};

	mi3_front #(.DW(DW), .FB(FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .m(m_in), .thr(thr_q),
		.out_valid(f_valid), .out_ready(f_ready), .m_o(f_m),
		.cofmag(f_cmag), .cofneg(f_cneg), .detmag(f_dmag), .detneg(f_dneg), .inv(f_inv)
	);

	// pack and unpack queue entries
	always_comb begin
		wr_ent = '0;
		for (int i = 0; i < ELEMS; i++) begin
			wr_ent[MB + i*DW +: DW]     = f_m[i];
			wr_ent[CB + i*2*DW +: 2*DW] = f_cmag[i];
			h_m[i]    = rd_ent[MB + i*DW +: DW];
			h_cmag[i] = rd_ent[CB + i*2*DW +: 2*DW];
		end
		wr_ent[NB +: ELEMS]   = f_cneg;
		wr_ent[DB +: 3*DW+1]  = f_dmag;
		wr_ent[DB + 3*DW + 1] = f_dneg;
		wr_ent[DB + 3*DW + 2] = f_inv;
	end

	mi3_queue #(.W(EW)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(wr_ent),
		.rd_valid(q_valid), .rd_pop(q_pop), .rd_data(rd_ent)
	);

	mi3_back #(.DW(DW), .FB(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_pop(q_pop),
		.h_m(h_m), .h_cofmag(h_cmag), .h_cofneg(rd_ent[NB +: ELEMS]),
		.h_detmag(rd_ent[DB +: 3*DW+1]), .h_detneg(rd_ent[DB + 3*DW + 1]),
		.h_inv(rd_ent[DB + 3*DW + 2]),
		.out_valid(out_valid), .out_ready(out_ready), .r(r_o), .invertible(invertible)
	);

	assign r00 = r_o[0]; assign r01 = r_o[1]; assign r02 = r_o[2];
	assign r10 = r_o[3]; assign r11 = r_o[4]; assign r12 = r_o[5];
	assign r20 = r_o[6]; assign r21 = r_o[7]; assign r22 = r_o[8];

endmodule

/* rtl/mi3_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_checker
// Port-level checks on the matrix inverse block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mi3_checker import mi3_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	localparam int PW  = (DATA_WIDTH - 1 > 32) ? 64 : 32,
	localparam int SL  = (PW == 64) ? 3 : 2,
	localparam int PAW = SL + 1
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         psel,
	input logic                         penable,
	input logic                         pwrite,
	input logic [PAW-1:0]               paddr,
	input logic [PW-1:0]                pwdata,
	input logic [PW-1:0]                prdata,
	input logic                         pready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic signed [DATA_WIDTH-1:0] r00,
	input logic signed [DATA_WIDTH-1:0] r22,
	input logic                         invertible
);

	localparam logic [PW-1:0] THR_MASK = PW'({(DATA_WIDTH-1){1'b1}});

	logic wr_thr, rd_thr;
	assign wr_thr = psel && penable && pwrite && pready && paddr[PAW-1:SL] == 1'(REG_DET_THR);
	assign rd_thr = paddr[PAW-1:SL] == 1'(REG_DET_THR);

	// stalled result beat keeps valid and payload
	`ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid, "result beat dropped")
	`ASSERT_CLK(a_out_stable, out_valid && !out_ready |=> $stable(r00) && $stable(r22) && $stable(invertible), "stalled payload changed")
	// threshold write reads back, masked to its width
	`ASSERT_CLK(a_thr_readback, wr_thr |=> !rd_thr || prdata == ($past(pwdata) & THR_MASK), "threshold readback wrong")
	// register port never inserts wait states
	`ASSERT_CLK(a_pready, pready, "pready low")

endmodule

bind matrix_inverse_3x3 mi3_checker #(.DATA_WIDTH(DATA_WIDTH)) u_mi3_checker (.*);
